@@ rtl/core/prefix_coded_lz_token_decoder_unit_macros.svh @@
// Assertion macros shared by the token decoder RTL.
`ifndef PREFIX_CODED_LZ_TOKEN_DECODER_UNIT_MACROS_SVH
`define PREFIX_CODED_LZ_TOKEN_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLZD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLZD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/plzd_pkg.sv @@
// Types, codes and constants of the prefix-coded LZ token decoder.
package plzd_pkg;

  typedef enum logic [4:0] {
    PH_LEN_PREFIX  = 5'b00001,
    PH_LITERAL     = 5'b00010,
    PH_LEN_SUFFIX  = 5'b00100,
    PH_DIST_PREFIX = 5'b01000,
    PH_DIST_SUFFIX = 5'b10000
  } phase_t;

  localparam logic [3:0]  LEN_PREFIX_MAX  = 4'd7;
  localparam logic [3:0]  DIST_PREFIX_MAX = 4'd4;
  localparam logic [4:0]  DIST_SUFFIX_MIN = 5'd9;
  localparam logic [4:0]  LIT_BITS        = 5'd8;
  localparam logic [13:0] DIST_BASE_UNIT  = 14'd512;

  typedef struct packed {
    logic [15:0] bit_buffer;
    logic [4:0]  bits_held;
    phase_t      phase;
    logic [3:0]  prefix_count;
    logic [13:0] prefix_base;
    logic [8:0]  pending_length;
    logic        finished;
  } plzd_state_t;

  typedef struct packed {
    logic ge_start;    // byte count already at or past the size
    logic done_lit;    // a literal now would reach the size
    logic done_match;  // the pending match would reach the size
  } plzd_size_flags_t;

  typedef struct packed {
    logic        got;
    logic        is_match;
    logic [7:0]  literal_value;
    logic [8:0]  match_length;
    logic [13:0] match_distance;
    logic        done;
  } plzd_result_t;

  localparam plzd_state_t STATE_RESET = '{
    bit_buffer:     16'd0,
    bits_held:      5'd0,
    phase:          PH_LEN_PREFIX,
    prefix_count:   4'd0,
    prefix_base:    14'd0,
    pending_length: 9'd0,
    finished:       1'b0
  };

endpackage

@@ rtl/core/plzd_byte_parse.sv @@
// Bit-by-bit token parse of one compressed byte, most significant bit first.
module plzd_byte_parse import plzd_pkg::*; (
  input  plzd_state_t      cur,
  input  logic [7:0]       byte_in,
  input  plzd_size_flags_t flags,
  output plzd_state_t      nxt,
  output plzd_result_t     res
);

  function automatic plzd_state_t start_token(plzd_state_t s);
    plzd_state_t t;
    t = s;
    t.phase        = PH_LEN_PREFIX;
    t.prefix_count = 4'd0;
    t.prefix_base  = 14'd0;
    t.bit_buffer   = 16'd0;
    t.bits_held    = 5'd0;
    return t;
  endfunction

  always_comb begin
    plzd_state_t  s;
    plzd_result_t r;
    logic [7:0]   sr;
    logic         bit_v;
    s     = cur;
    r     = '0;
    sr    = byte_in;
    bit_v = 1'b0;
    for (int i = 0; i < 8; i++) begin
      bit_v = sr[7];
      sr    = {sr[6:0], 1'b0};
      if (!s.finished) begin
        unique case (s.phase)
          PH_LITERAL: begin
            s.bit_buffer = {s.bit_buffer[14:0], bit_v};
            s.bits_held  = s.bits_held + 5'd1;
            if (s.bits_held >= LIT_BITS && !r.got) begin
              r.got           = 1'b1;
              r.is_match      = 1'b0;
              r.literal_value = s.bit_buffer[7:0];
              r.done          = flags.done_lit;
              s.finished      = s.finished | flags.done_lit;
              s = start_token(s);
            end
          end
          PH_LEN_SUFFIX: begin
            s.bit_buffer = {s.bit_buffer[14:0], bit_v};
            s.bits_held  = s.bits_held + 5'd1;
            if (s.bits_held >= {1'b0, s.prefix_count}) begin
              s.pending_length = s.prefix_base[8:0] + s.bit_buffer[8:0] + 9'd2;
              s.phase          = PH_DIST_PREFIX;
              s.prefix_count   = 4'd0;
              s.prefix_base    = 14'd0;
              s.bit_buffer     = 16'd0;
              s.bits_held      = 5'd0;
            end
          end
          PH_DIST_PREFIX: begin
            if (bit_v) begin
              s.prefix_base  = s.prefix_base + (DIST_BASE_UNIT << s.prefix_count);
              s.prefix_count = s.prefix_count + 4'd1;
              if (s.prefix_count >= DIST_PREFIX_MAX) begin
                s.phase = PH_DIST_SUFFIX;
              end
            end else begin
              s.phase = PH_DIST_SUFFIX;
            end
            s.bit_buffer = 16'd0;
            s.bits_held  = 5'd0;
          end
          PH_DIST_SUFFIX: begin
            s.bit_buffer = {s.bit_buffer[14:0], bit_v};
            s.bits_held  = s.bits_held + 5'd1;
            if (s.bits_held >= DIST_SUFFIX_MIN + {1'b0, s.prefix_count} && !r.got) begin
              r.got            = 1'b1;
              r.is_match       = 1'b1;
              r.match_length   = s.pending_length;
              r.match_distance = s.prefix_base + s.bit_buffer[13:0] + 14'd1;
              r.done           = flags.done_match;
              s.finished       = s.finished | flags.done_match;
              s = start_token(s);
            end
          end
          default: begin
            // length prefix; a token boundary also checks the size
            if (s.prefix_count == 4'd0 && flags.ge_start) begin
              s.finished = 1'b1;
            end else begin
              s.bit_buffer = 16'd0;
              s.bits_held  = 5'd0;
              if (bit_v) begin
                s.prefix_base  = s.prefix_base + (14'd1 << s.prefix_count);
                s.prefix_count = s.prefix_count + 4'd1;
                s.phase = (s.prefix_count >= LEN_PREFIX_MAX) ? PH_LEN_SUFFIX
                                                             : PH_LEN_PREFIX;
              end else begin
                s.phase = (s.prefix_count == 4'd0) ? PH_LITERAL : PH_LEN_SUFFIX;
              end
            end
          end
        endcase
      end
    end
    nxt = s;
    res = r;
  end

endmodule

@@ rtl/core/prefix_coded_lz_token_decoder_unit.sv @@
// Top level of the prefix-coded LZ token decoder: byte input, token output.
// Takes one compressed byte per clock unless byte_stall holds it, and emits at
// most one literal or match token per byte. The input register holds the byte
// and the token register the token; the eight-step bit parse and the byte-count
// add and compare against orig_size sit combinationally between them.
// A byte flagged start_of_stream clears all parse state and the byte count
// before it is used; orig_size is kept. Once the count reaches orig_size the
// decoder drops every byte until the next start_of_stream.
`include "prefix_coded_lz_token_decoder_unit_macros.svh"

module prefix_coded_lz_token_decoder_unit import plzd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic        start_of_stream,
  input  logic [7:0]  in_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic        is_match,
  output logic [7:0]  literal_value,
  output logic [8:0]  match_length,
  output logic [13:0] match_distance,
  output logic        stream_done
);

  logic [31:0]      orig_size;
  logic             s1_valid;
  logic             s1_sos;
  logic [7:0]       s1_byte;
  plzd_state_t      st;
  plzd_state_t      st_cur;
  plzd_state_t      st_next;
  plzd_result_t     res;
  plzd_size_flags_t flags;
  logic [32:0]      bytes_out;
  logic [32:0]      bytes_out_cur;
  logic [32:0]      bytes_out_next;
  logic [32:0]      sum_lit;
  logic [32:0]      sum_match;
  logic             out_free;
  logic             s1_adv;

  assign out_free   = !token_valid || !token_stall;
  assign s1_adv     = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  assign st_cur        = s1_sos ? STATE_RESET : st;
  assign bytes_out_cur = s1_sos ? 33'd0 : bytes_out;
  assign sum_lit       = bytes_out_cur + 33'd1;
  assign sum_match     = bytes_out_cur + {24'd0, st_cur.pending_length};

  assign flags.ge_start   = bytes_out_cur >= {1'b0, orig_size};
  assign flags.done_lit   = sum_lit >= {1'b0, orig_size};
  assign flags.done_match = sum_match >= {1'b0, orig_size};

  plzd_byte_parse u_parse (
    .cur     (st_cur),
    .byte_in (s1_byte),
    .flags   (flags),
    .nxt     (st_next),
    .res     (res)
  );

  always_comb begin
    if (res.got) begin
      bytes_out_next = res.is_match ? sum_match : sum_lit;
    end else begin
      bytes_out_next = bytes_out_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orig_size   <= 32'd0;
      s1_valid    <= 1'b0;
      st          <= STATE_RESET;
      bytes_out   <= 33'd0;
      token_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        orig_size <= cfg_wr_data;
      end
      if (!byte_stall) begin
        s1_valid <= byte_valid;
      end
      if (s1_adv) begin
        st          <= st_next;
        bytes_out   <= bytes_out_next;
        token_valid <= res.got;
      end else if (out_free) begin
        token_valid <= 1'b0;
      end
    end
  end

  // payload registers: load the byte on accept, the token when one completes
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_sos  <= start_of_stream;
      s1_byte <= in_byte;
    end
    if (s1_adv && res.got) begin
      is_match       <= res.is_match;
      literal_value  <= res.literal_value;
      match_length   <= res.match_length;
      match_distance <= res.match_distance;
      stream_done    <= res.done;
    end
  end

  `PLZD_ASSERT_NOW(a_match_fields, clk, rst, token_valid && is_match, match_length >= 9'd3 && match_distance != 14'd0, "match token with bad length or distance")
  `PLZD_ASSERT_NEXT(a_done_sets_finished, clk, rst, s1_adv && res.got && res.done, st.finished, "size reached but decoder not finished")
  `PLZD_ASSERT_NEXT(a_no_token_after_finish, clk, rst, s1_adv && st.finished && !s1_sos, !token_valid, "token emitted after finish")
  `PLZD_ASSERT_NEXT(a_count_monotonic, clk, rst, s1_adv && !s1_sos, bytes_out >= $past(bytes_out), "byte count went backward")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the prefix-coded LZ token decoder unit.
module testbench;
  import plzd_pkg::*;

  typedef struct packed {
    bit        is_match;
    bit [7:0]  lit_val;
    bit [8:0]  len_val;
    bit [13:0] dist_val;
    bit        done;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic        start_of_stream = 1'b0;
  logic [7:0]  in_byte = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic        is_match;
  logic [7:0]  literal_value;
  logic [8:0]  match_length;
  logic [13:0] match_distance;
  logic        stream_done;

  prefix_coded_lz_token_decoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .start_of_stream(start_of_stream),
    .in_byte        (in_byte),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .is_match       (is_match),
    .literal_value  (literal_value),
    .match_length   (match_length),
    .match_distance (match_distance),
    .stream_done    (stream_done)
  );

  always #10 clk = ~clk;

  // Decoder state mirrored by the bench
  logic [31:0] size_reg;
  logic [15:0] dec_buf;
  logic [4:0]  dec_held;
  phase_t      dec_phase;
  logic [3:0]  dec_count;
  logic [13:0] dec_base;
  logic [8:0]  dec_len;
  logic [32:0] dec_total;
  logic        dec_finished;

  token_t      pending_tokens[$];
  bit          stream_bits[$];
  int unsigned bytes_sent = 0;
  int          errors = 0;
  bit          no_idle = 1'b0;

  function automatic void clear_parse();
    dec_buf      = '0;
    dec_held     = '0;
    dec_phase    = PH_LEN_PREFIX;
    dec_count    = '0;
    dec_base     = '0;
    dec_len      = '0;
    dec_total    = '0;
    dec_finished = 1'b0;
  endfunction

  function automatic void shift_bit(input bit bt);
    dec_buf  = {dec_buf[14:0], bt};
    dec_held = dec_held + 5'd1;
  endfunction

  function automatic void close_token(input bit m, input bit [7:0] lit, input bit [8:0] len,
                                      input bit [13:0] distance, output token_t tok);
    dec_total    = dec_total + (m ? {24'd0, len} : 33'd1);
    tok.is_match = m;
    tok.lit_val  = lit;
    tok.len_val  = len;
    tok.dist_val = distance;
    tok.done     = dec_total >= {1'b0, size_reg};
    if (tok.done) dec_finished = 1'b1;
    dec_phase = PH_LEN_PREFIX;
    dec_count = '0;
    dec_base  = '0;
    dec_buf   = '0;
    dec_held  = '0;
  endfunction

  // Parse one byte MSB first; return 1 if it completes a token
  function automatic bit decode_byte(input bit sos, input bit [7:0] b, output token_t tok);
    bit got;
    bit bt;
    got = 1'b0;
    tok = '0;
    if (sos) clear_parse();
    if (dec_finished) return 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (dec_finished) break;
      bt = b[i];
      case (dec_phase)
        PH_LITERAL: begin
          shift_bit(bt);
          if (dec_held >= LIT_BITS && !got) begin
            close_token(1'b0, dec_buf[7:0], 9'd0, 14'd0, tok);
            got = 1'b1;
          end
        end
        PH_LEN_SUFFIX: begin
          shift_bit(bt);
          if (dec_held >= dec_count) begin
            dec_len   = 9'({2'd0, dec_base} + dec_buf + 16'd2);
            dec_phase = PH_DIST_PREFIX;
            dec_count = '0;
            dec_base  = '0;
            dec_buf   = '0;
            dec_held  = '0;
          end
        end
        PH_DIST_PREFIX: begin
          if (bt) begin
            dec_base  = dec_base + (DIST_BASE_UNIT << dec_count);
            dec_count = dec_count + 4'd1;
            if (dec_count >= DIST_PREFIX_MAX) dec_phase = PH_DIST_SUFFIX;
          end else begin
            dec_phase = PH_DIST_SUFFIX;
          end
          dec_buf  = '0;
          dec_held = '0;
        end
        PH_DIST_SUFFIX: begin
          shift_bit(bt);
          if (dec_held >= DIST_SUFFIX_MIN + dec_count && !got) begin
            close_token(1'b1, 8'd0, dec_len, 14'({2'd0, dec_base} + dec_buf + 16'd1), tok);
            got = 1'b1;
          end
        end
        default: begin
          // Size check happens only at a token boundary
          if (dec_count == 0 && dec_total >= {1'b0, size_reg}) begin
            dec_finished = 1'b1;
          end else begin
            dec_buf  = '0;
            dec_held = '0;
            if (bt) begin
              dec_base  = dec_base + (14'd1 << dec_count);
              dec_count = dec_count + 4'd1;
              dec_phase = (dec_count >= LEN_PREFIX_MAX) ? PH_LEN_SUFFIX : PH_LEN_PREFIX;
            end else begin
              dec_phase = (dec_count == 0) ? PH_LITERAL : PH_LEN_SUFFIX;
            end
          end
        end
      endcase
    end
    return got;
  endfunction

  // Mostly no idle, sometimes a short gap, rarely a long stretch
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Token encoder: build a bit sequence MSB first
  function automatic void put_bits(input int unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endfunction

  function automatic void put_ones(input int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(1'b1);
  endfunction

  function automatic void put_literal(input bit [7:0] v);
    put_bits(0, 1);
    put_bits(32'(v), 8);
  endfunction

  function automatic void put_match(input int unsigned len, input int unsigned distance);
    int unsigned l;
    int unsigned d;
    int k;
    int c;
    l = len - 2;
    k = 0;
    while (k < 7 && l >= (2 << k) - 1) k++;
    put_ones(k);
    if (k < 7) put_bits(0, 1);
    put_bits(l - ((1 << k) - 1), k);
    d = distance - 1;
    c = 0;
    while (c < 4 && d >= 512 * ((2 << c) - 1)) c++;
    put_ones(c);
    if (c < 4) put_bits(0, 1);
    put_bits(d - 512 * ((1 << c) - 1), 9 + c);
  endfunction

  function automatic void put_random_token();
    int unsigned len;
    int unsigned distance;
    if ($urandom_range(0, 2) == 0) begin
      put_literal(8'($urandom_range(0, 255)));
    end else begin
      len      = ($urandom_range(0, 1) == 0) ? $urandom_range(3, 10) : $urandom_range(3, 256);
      distance = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 600)
                                             : $urandom_range(1, 15872);
      put_match(len, distance);
    end
  endfunction

  task automatic send_byte(input bit sos, input bit [7:0] b);
    int gap;
    token_t tok;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid      <= 1'b1;
    start_of_stream <= sos;
    in_byte         <= b;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    if (decode_byte(sos, b, tok)) pending_tokens.push_back(tok);
    bytes_sent++;
  endtask

  // Pad to a byte boundary with random bits, then send up to max_bytes
  task automatic send_stream(input bit sos_first, input int max_bytes);
    bit [7:0] b;
    bit first;
    int n;
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
    first = sos_first;
    n = 0;
    while (stream_bits.size() > 0 && n < max_bytes) begin
      for (int i = 7; i >= 0; i--) b[i] = stream_bits.pop_front();
      send_byte(first, b);
      first = 1'b0;
      n++;
    end
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    // bytes that finish no token may still be in the pipeline
    repeat (6) @(posedge clk);
  endtask

  task automatic set_size(input logic [31:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    size_reg = v;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_token_forms();
    set_size(32'hFFFF_FFFF);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_match(3, 1);
    put_match(256, 15872);
    put_match(9, 1537);
    put_match(33, 7681);
    send_stream(1'b1, 1000);
  endtask

  // Zero size: the first bit stops decoding
  task automatic test_zero_size();
    set_size(32'd0);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h00);
  endtask

  task automatic test_size_reached();
    set_size(32'd3);
    // exact hit on the third literal, the fourth is dropped
    put_literal(8'h41);
    put_literal(8'h42);
    put_literal(8'h43);
    put_literal(8'h44);
    send_stream(1'b1, 1000);
    // restart, then overshoot with a match
    put_literal(8'h45);
    put_match(3, 2);
    send_stream(1'b1, 1000);
  endtask

  task automatic test_size_change_mid_token();
    set_size(32'hFFFF_FFFF);
    put_literal(8'h11);
    put_match(40, 3000);
    send_stream(1'b1, 2);
    // the match has begun; it must still complete under the new size
    set_size(32'd1);
    send_stream(1'b0, 1000);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1, 2:    return 32'hFFFF_FFFF;
      3:       return 32'd1;
      4, 5:    return $urandom_range(2, 50);
      6, 7, 8: return $urandom_range(50, 2000);
      9:       return $urandom;
      default: return $urandom_range(2000, 20000);
    endcase
  endfunction

  task automatic test_random_streams();
    int unsigned first;
    int unsigned idx;
    first = bytes_sent;
    while (bytes_sent - first < 1950) begin
      set_size(pick_size());
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 6)) begin
        repeat ($urandom_range(1, 30)) put_random_token();
        // break some sequences: flip a bit or cut the tail
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, stream_bits.size() - 1);
          stream_bits[idx] = ~stream_bits[idx];
        end
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, stream_bits.size() / 2)) void'(stream_bits.pop_back());
        send_stream($urandom_range(0, 7) != 0, 100000);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4))
            send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : token_stall_driver
    int n;
    @(posedge clk);
    forever begin
      token_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        token_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : token_check
    token_t want;
    if (!rst && token_valid === 1'b1 && token_stall === 1'b0) begin
      if (pending_tokens.size() == 0) begin
        $error("token with none expected: is_match %0d", is_match);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("is_match", 32'(want.is_match), 32'(is_match));
        check_field("literal_value", 32'(want.lit_val), 32'(literal_value));
        check_field("match_length", 32'(want.len_val), 32'(match_length));
        check_field("match_distance", 32'(want.dist_val), 32'(match_distance));
        check_field("stream_done", 32'(want.done), 32'(stream_done));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    size_reg = '0;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_token_forms();
    test_zero_size();
    test_size_reached();
    test_size_change_mid_token();
    test_random_streams();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
